### rtl/core/mmts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmts_pkg: shared definitions for the timed motor sequencer
// Widths, command, phase and mode codes, and the transaction token that
// walks the chain of motor cells.
// ----------------------------------------------------------------------------
package mmts_pkg;

    // configuration defaults and limits
    localparam int NUM_MOTORS_DEF = 6;
    localparam int MAX_MOTORS     = 16;
    localparam int CNT_W          = $clog2(MAX_MOTORS + 1);

    // field widths
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 3;
    localparam int WT_W       = 16;
    localparam int DIR_W      = 2;
    localparam int LVL_W      = 8;
    localparam int LEN_W      = 23;
    localparam int TICK_W     = 24;
    localparam int DUTY_W     = 10;
    localparam int PROD_W     = 12;
    localparam int PH_W       = 3;
    localparam int MODE_W     = 2;
    localparam int MASK_W     = 6;
    localparam int CNT_OUT_W  = 3;

    // scaling constants
    localparam int TIME_SCALE = 100;
    localparam int DUTY_SCALE = 10;
    localparam int DUTY_MAX   = 1000;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CFG   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd3;

    // motor phase codes
    localparam logic [PH_W-1:0] PH_UNCONF = 3'd0;
    localparam logic [PH_W-1:0] PH_CONF   = 3'd1;
    localparam logic [PH_W-1:0] PH_WAIT   = 3'd2;
    localparam logic [PH_W-1:0] PH_RUN    = 3'd3;
    localparam logic [PH_W-1:0] PH_DONE   = 3'd4;

    // sequencer mode codes
    localparam logic [MODE_W-1:0] MODE_READY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PENDING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORKING = 2'd2;

    // token handed from cell to cell
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  motor;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  dly;
        logic [DUTY_W-1:0] cfg_a;
        logic [DUTY_W-1:0] cfg_b;
        logic              lap;
        logic              begin_run;
        logic              working;
        logic              start_ok;
        logic              ended;
        logic [CNT_W-1:0]  count;
        logic [PH_W-1:0]   status;
        logic [DUTY_W-1:0] rep_a;
        logic [DUTY_W-1:0] rep_b;
        logic [MASK_W-1:0] mask;
    } mmts_tok_t;

endpackage
`default_nettype wire

### rtl/core/multi_motor_timed_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_motor_timed_sequencer: timed run sequencer for PWM motor drivers
// Configure, start, count and evaluate transactions drive a row of motor
// cells; one result transaction reports the sequencer and addressed motor.
// ----------------------------------------------------------------------------
// Each input transaction is latched into a one-entry buffer and then sent as a
// token down a chain of NUM_MOTORS cells, one cell per cycle, and its result
// is registered when it leaves the last cell. An evaluate transaction during
// a run passes through the chain twice: the token makes a first lap that
// begins the run and starts or stops motors and a second lap that retires
// finished motors in index order. One token is in the chain at a time; the
// next transaction is accepted into the buffer while the previous one is in
// flight and enters the chain once the result register has been emptied.
module multi_motor_timed_sequencer #(
    parameter int NUM_MOTORS = mmts_pkg::NUM_MOTORS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [mmts_pkg::CMD_W-1:0]     s_cmd,
    input  wire logic [mmts_pkg::IDX_W-1:0]     s_motor,
    input  wire logic [mmts_pkg::WT_W-1:0]      s_work_time,
    input  wire logic [mmts_pkg::WT_W-1:0]      s_delay_time,
    input  wire logic [mmts_pkg::DIR_W-1:0]     s_direction,
    input  wire logic [mmts_pkg::LVL_W-1:0]     s_pwm_level,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [mmts_pkg::MODE_W-1:0]         m_module_state,
    output logic                                m_driver_on,
    output logic [mmts_pkg::MASK_W-1:0]         m_run_mask,
    output logic [mmts_pkg::PH_W-1:0]           m_motor_status,
    output logic [mmts_pkg::DUTY_W-1:0]         m_duty_a,
    output logic [mmts_pkg::DUTY_W-1:0]         m_duty_b,
    output logic [mmts_pkg::CNT_OUT_W-1:0]      m_active_count
);

    logic                          buf_vld_reg;
    mmts_pkg::mmts_tok_t           buf_reg;
    logic                          busy_reg;
    logic [mmts_pkg::MODE_W-1:0]   mode_reg;
    logic                          drv_reg;
    logic [mmts_pkg::CNT_W-1:0]    count_reg;
    logic                          m_valid_reg;
    logic [mmts_pkg::MODE_W-1:0]   out_mode_reg;
    logic                          out_drv_reg;
    logic [mmts_pkg::MASK_W-1:0]   out_mask_reg;
    logic [mmts_pkg::PH_W-1:0]     out_status_reg;
    logic [mmts_pkg::DUTY_W-1:0]   out_a_reg;
    logic [mmts_pkg::DUTY_W-1:0]   out_b_reg;
    logic [mmts_pkg::CNT_OUT_W-1:0] out_count_reg;

    logic                          accept;
    logic                          launch;
    logic                          recirc;
    logic                          finish;
    logic [mmts_pkg::PROD_W-1:0]   duty_prod;
    logic [mmts_pkg::DUTY_W-1:0]   duty_sat;
    mmts_pkg::mmts_tok_t           acc_tok;
    mmts_pkg::mmts_tok_t           launch_tok;
    mmts_pkg::mmts_tok_t           recirc_tok;
    mmts_pkg::mmts_tok_t           last_tok;
    logic [mmts_pkg::MODE_W-1:0]   mode_fin;
    logic                          drv_fin;
    logic [mmts_pkg::CNT_W-1:0]    count_fin;

    logic [NUM_MOTORS:0]           chain_vld;
    mmts_pkg::mmts_tok_t           chain_tok [0:NUM_MOTORS];

    assign s_ready = !buf_vld_reg;
    assign accept  = s_valid && s_ready;
    assign launch  = buf_vld_reg && !busy_reg && !m_valid_reg;

    // scale the incoming transaction
    assign duty_prod = mmts_pkg::PROD_W'(s_pwm_level) * mmts_pkg::PROD_W'(mmts_pkg::DUTY_SCALE);
    assign duty_sat  = (duty_prod > mmts_pkg::PROD_W'(mmts_pkg::DUTY_MAX)) ?
                       mmts_pkg::DUTY_W'(mmts_pkg::DUTY_MAX) : duty_prod[mmts_pkg::DUTY_W-1:0];

    always_comb begin
        acc_tok       = '0;
        acc_tok.cmd   = s_cmd;
        acc_tok.motor = s_motor;
        acc_tok.len   = mmts_pkg::LEN_W'(s_work_time) * mmts_pkg::LEN_W'(mmts_pkg::TIME_SCALE);
        acc_tok.dly   = mmts_pkg::LEN_W'(s_delay_time) * mmts_pkg::LEN_W'(mmts_pkg::TIME_SCALE);
        acc_tok.cfg_a = s_direction[0] ? duty_sat : '0;
        acc_tok.cfg_b = s_direction[1] ? duty_sat : '0;
    end

    // input buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_vld_reg <= 1'b0;
        end else if (accept) begin
            buf_vld_reg <= 1'b1;
        end else if (launch) begin
            buf_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            buf_reg <= acc_tok;
        end
    end

    // token entering the chain: fresh launch or second lap
    always_comb begin
        launch_tok           = buf_reg;
        launch_tok.begin_run = (mode_reg == mmts_pkg::MODE_PENDING);
        launch_tok.working   = (mode_reg == mmts_pkg::MODE_PENDING) ||
                               (mode_reg == mmts_pkg::MODE_WORKING);
        launch_tok.count     = (mode_reg == mmts_pkg::MODE_PENDING) ? '0 : count_reg;
        recirc_tok           = last_tok;
        recirc_tok.lap       = 1'b1;
    end

    assign last_tok     = chain_tok[NUM_MOTORS];
    assign recirc       = chain_vld[NUM_MOTORS] && !last_tok.lap &&
                          last_tok.cmd == mmts_pkg::CMD_EVAL && last_tok.working;
    assign finish       = chain_vld[NUM_MOTORS] && !recirc;
    assign chain_vld[0] = launch || recirc;
    assign chain_tok[0] = recirc ? recirc_tok : launch_tok;

    // row of motor cells
    for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_cell
        mmts_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .in_vld  (chain_vld[g]),
            .in_tok  (chain_tok[g]),
            .out_vld (chain_vld[g+1]),
            .out_tok (chain_tok[g+1])
        );
    end

    // sequencer mode update when a token leaves the chain
    always_comb begin
        mode_fin  = mode_reg;
        drv_fin   = drv_reg;
        count_fin = count_reg;
        unique case (last_tok.cmd) inside
            mmts_pkg::CMD_START: begin
                if (last_tok.start_ok && mode_reg != mmts_pkg::MODE_WORKING) begin
                    mode_fin = mmts_pkg::MODE_PENDING;
                end
            end
            mmts_pkg::CMD_EVAL: begin
                if (last_tok.working) begin
                    count_fin = last_tok.count;
                    mode_fin  = mmts_pkg::MODE_WORKING;
                    drv_fin   = 1'b1;
                    if (last_tok.ended) begin
                        mode_fin = mmts_pkg::MODE_READY;
                        drv_fin  = 1'b0;
                    end
                end
            end
            mmts_pkg::CMD_CFG, mmts_pkg::CMD_COUNT: begin
            end
        endcase
    end

    // sequencer state and busy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= mmts_pkg::MODE_READY;
            drv_reg   <= 1'b0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end else begin
            if (finish) begin
                mode_reg  <= mode_fin;
                drv_reg   <= drv_fin;
                count_reg <= count_fin;
            end
            if (launch) begin
                busy_reg <= 1'b1;
            end else if (finish) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            out_mode_reg   <= mode_fin;
            out_drv_reg    <= drv_fin;
            out_mask_reg   <= last_tok.mask;
            out_status_reg <= last_tok.status;
            out_a_reg      <= last_tok.rep_a;
            out_b_reg      <= last_tok.rep_b;
            out_count_reg  <= count_fin[mmts_pkg::CNT_OUT_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_module_state = out_mode_reg;
    assign m_driver_on    = out_drv_reg;
    assign m_run_mask     = out_mask_reg;
    assign m_motor_status = out_status_reg;
    assign m_duty_a       = out_a_reg;
    assign m_duty_b       = out_b_reg;
    assign m_active_count = out_count_reg;

    // a finished token always finds the result register free
    a_fin_room: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> !m_valid_reg)
        else $error("result arrived while result register full");

    // driver enable follows the working mode
    a_drv_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        drv_reg == (mode_reg == mmts_pkg::MODE_WORKING))
        else $error("driver enable out of step with mode");

    // never more than one token in the chain
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(chain_vld[NUM_MOTORS:1]))
        else $error("more than one token in the chain");

    // active count bounded by the number of motors
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= NUM_MOTORS)
        else $error("active count exceeds motor count");

endmodule
`default_nettype wire

### rtl/core/mmts_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmts_cell: one motor cell of the sequencer chain
// Holds one motor's timing and duty state, applies the passing transaction
// token to it and registers the token for the next cell.
// ----------------------------------------------------------------------------
module mmts_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_vld,
    input  wire mmts_pkg::mmts_tok_t in_tok,
    output logic                     out_vld,
    output mmts_pkg::mmts_tok_t      out_tok
);

    logic [mmts_pkg::PH_W-1:0]   phase_reg,   phase_next;
    logic                        run_reg,     run_next;
    logic [mmts_pkg::DUTY_W-1:0] duty_a_reg,  duty_a_next;
    logic [mmts_pkg::DUTY_W-1:0] duty_b_reg,  duty_b_next;
    logic [mmts_pkg::LEN_W-1:0]  len_reg,     len_next;
    logic [mmts_pkg::LEN_W-1:0]  dly_reg,     dly_next;
    logic [mmts_pkg::TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [mmts_pkg::TICK_W-1:0] bmark_reg,   bmark_next;
    logic [mmts_pkg::TICK_W-1:0] emark_reg,   emark_next;
    mmts_pkg::mmts_tok_t         tok_reg,     tok_next;
    logic                        vld_reg;
    logic                        hit;

    // this cell is the addressed motor
    assign hit = (int'(in_tok.motor) == CELL_IDX);

    // per-motor update
    always_comb begin
        phase_next   = phase_reg;
        run_next     = run_reg;
        duty_a_next  = duty_a_reg;
        duty_b_next  = duty_b_reg;
        len_next     = len_reg;
        dly_next     = dly_reg;
        elapsed_next = elapsed_reg;
        bmark_next   = bmark_reg;
        emark_next   = emark_reg;
        tok_next     = in_tok;
        if (in_vld) begin
            unique case (in_tok.cmd)
                mmts_pkg::CMD_CFG: begin
                    if (hit) begin
                        len_next    = in_tok.len;
                        dly_next    = in_tok.dly;
                        duty_a_next = in_tok.cfg_a;
                        duty_b_next = in_tok.cfg_b;
                        if (in_tok.len != '0) begin
                            phase_next = mmts_pkg::PH_CONF;
                        end
                    end
                end
                mmts_pkg::CMD_START: begin
                    if (hit && phase_reg == mmts_pkg::PH_CONF) begin
                        tok_next.start_ok = 1'b1;
                    end
                end
                mmts_pkg::CMD_COUNT: begin
                    if ((phase_reg == mmts_pkg::PH_WAIT || phase_reg == mmts_pkg::PH_RUN) &&
                        elapsed_reg != mmts_pkg::TICK_MAX) begin
                        elapsed_next = elapsed_reg + mmts_pkg::TICK_W'(1);
                    end
                end
                mmts_pkg::CMD_EVAL: begin
                    if (in_tok.working && !in_tok.lap) begin
                        // first lap: join a new run, then start or stop
                        if (in_tok.begin_run && phase_reg == mmts_pkg::PH_CONF) begin
                            elapsed_next   = '0;
                            bmark_next     = mmts_pkg::TICK_W'(dly_reg);
                            emark_next     = mmts_pkg::TICK_W'(dly_reg) +
                                             mmts_pkg::TICK_W'(len_reg);
                            phase_next     = mmts_pkg::PH_WAIT;
                            tok_next.count = in_tok.count + mmts_pkg::CNT_W'(1);
                        end
                        if (phase_next == mmts_pkg::PH_WAIT) begin
                            if (bmark_next <= elapsed_next) begin
                                run_next   = 1'b1;
                                phase_next = mmts_pkg::PH_RUN;
                            end
                        end else if (phase_next == mmts_pkg::PH_RUN) begin
                            if (emark_reg <= elapsed_reg) begin
                                run_next    = 1'b0;
                                phase_next  = mmts_pkg::PH_DONE;
                                duty_a_next = '0;
                                duty_b_next = '0;
                            end
                        end
                    end else if (in_tok.working && !in_tok.ended) begin
                        // second lap: retire finished motors in index order
                        if (phase_reg == mmts_pkg::PH_DONE) begin
                            if (in_tok.count != '0) begin
                                tok_next.count = in_tok.count - mmts_pkg::CNT_W'(1);
                            end
                            phase_next = mmts_pkg::PH_UNCONF;
                        end
                        if (tok_next.count == '0) begin
                            tok_next.ended = 1'b1;
                        end
                    end
                end
            endcase
            // report the addressed motor and the running mask
            if (hit) begin
                tok_next.status = phase_next;
                tok_next.rep_a  = duty_a_next;
                tok_next.rep_b  = duty_b_next;
            end
            for (int b = 0; b < mmts_pkg::MASK_W; b++) begin
                if (b == CELL_IDX) begin
                    tok_next.mask[b] = run_next;
                end
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= mmts_pkg::PH_UNCONF;
            run_reg    <= 1'b0;
            duty_a_reg <= '0;
            duty_b_reg <= '0;
            vld_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            run_reg    <= run_next;
            duty_a_reg <= duty_a_next;
            duty_b_reg <= duty_b_next;
            vld_reg    <= in_vld;
        end
    end

    // timing payload and token
    always_ff @(posedge aclk) begin
        len_reg     <= len_next;
        dly_reg     <= dly_next;
        elapsed_reg <= elapsed_next;
        bmark_reg   <= bmark_next;
        emark_reg   <= emark_next;
        tok_reg     <= tok_next;
    end

    assign out_vld = vld_reg;
    assign out_tok = tok_reg;

endmodule
`default_nettype wire

### verif/multi_motor_timed_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_motor_timed_sequencer_tb: self-checking bench for the motor sequencer
// Drives configure, start, count and evaluate transactions with random gaps
// and back-pressure, tracks the sequencer in a local model and compares every
// result transaction with the predicted sequencer and motor report.
// ----------------------------------------------------------------------------
module multi_motor_timed_sequencer_tb;
    import mmts_pkg::*;

    localparam int NMOT           = NUM_MOTORS_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int PRINT_CAP      = 40;

    // drive direction codes
    localparam logic [DIR_W-1:0] DIR_STOP  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;
    localparam logic [DIR_W-1:0] DIR_HOLD  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic                 drive;
        logic [MASK_W-1:0]    mask;
        logic [PH_W-1:0]      status;
        logic [DUTY_W-1:0]    duty_a;
        logic [DUTY_W-1:0]    duty_b;
        logic [CNT_OUT_W-1:0] active;
    } seq_report_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd          = '0;
    logic [IDX_W-1:0]     s_motor        = '0;
    logic [WT_W-1:0]      s_work_time    = '0;
    logic [WT_W-1:0]      s_delay_time   = '0;
    logic [DIR_W-1:0]     s_direction    = '0;
    logic [LVL_W-1:0]     s_pwm_level    = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [MODE_W-1:0]    m_module_state;
    logic                 m_driver_on;
    logic [MASK_W-1:0]    m_run_mask;
    logic [PH_W-1:0]      m_motor_status;
    logic [DUTY_W-1:0]    m_duty_a;
    logic [DUTY_W-1:0]    m_duty_b;
    logic [CNT_OUT_W-1:0] m_active_count;

    // model of the sequencer state
    logic [PH_W-1:0]   mot_phase   [NMOT];
    logic [LEN_W-1:0]  mot_len     [NMOT];
    logic [LEN_W-1:0]  mot_dly     [NMOT];
    logic [TICK_W-1:0] mot_elapsed [NMOT];
    logic [TICK_W-1:0] mot_begin   [NMOT];
    logic [TICK_W-1:0] mot_end     [NMOT];
    logic [DIR_W-1:0]  mot_dir     [NMOT];
    logic [DUTY_W-1:0] mot_duty_a  [NMOT];
    logic [DUTY_W-1:0] mot_duty_b  [NMOT];
    logic              mot_pwm     [NMOT];
    logic [MODE_W-1:0] seq_mode;
    int                seq_count;
    logic              seq_drive;

    seq_report_t due_reports[$];
    seq_report_t got_rep;
    seq_report_t want_rep;

    int gap_max        = 19;
    int stall_max      = 19;
    int ready_wait     = 0;
    int items_sent     = 0;
    int reports_seen   = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;

    multi_motor_timed_sequencer DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_motor        (s_motor),
        .s_work_time    (s_work_time),
        .s_delay_time   (s_delay_time),
        .s_direction    (s_direction),
        .s_pwm_level    (s_pwm_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_module_state (m_module_state),
        .m_driver_on    (m_driver_on),
        .m_run_mask     (m_run_mask),
        .m_motor_status (m_motor_status),
        .m_duty_a       (m_duty_a),
        .m_duty_b       (m_duty_b),
        .m_active_count (m_active_count)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // advance the model by one transaction and return the report it causes
    function automatic seq_report_t step_sequencer(
        input logic [CMD_W-1:0] cmd,
        input logic [IDX_W-1:0] mi,
        input logic [WT_W-1:0]  wt,
        input logic [WT_W-1:0]  dl,
        input logic [DIR_W-1:0] dir,
        input logic [LVL_W-1:0] lvl
    );
        seq_report_t r;
        logic        hit;
        logic        ending;
        int          m;
        int          i;
        int          d;
        hit    = (mi < NMOT);
        m      = hit ? int'(mi) : 0;
        ending = 1'b0;
        case (cmd)
            CMD_CFG: begin
                if (hit) begin
                    mot_len[m] = LEN_W'(int'(wt) * TIME_SCALE);
                    mot_dly[m] = LEN_W'(int'(dl) * TIME_SCALE);
                    mot_dir[m] = dir;
                    d = int'(lvl) * DUTY_SCALE;
                    if (d > DUTY_MAX) d = DUTY_MAX;
                    mot_duty_a[m] = (dir == DIR_LEFT || dir == DIR_HOLD) ? DUTY_W'(d) : '0;
                    mot_duty_b[m] = (dir == DIR_RIGHT || dir == DIR_HOLD) ? DUTY_W'(d) : '0;
                    if (wt != 0) mot_phase[m] = PH_CONF;
                end
            end
            CMD_START: begin
                if (hit && seq_mode != MODE_WORKING && mot_phase[m] == PH_CONF)
                    seq_mode = MODE_PENDING;
            end
            CMD_COUNT: begin
                for (i = 0; i < NMOT; i++)
                    if ((mot_phase[i] == PH_WAIT || mot_phase[i] == PH_RUN) &&
                        mot_elapsed[i] != TICK_MAX)
                        mot_elapsed[i] = mot_elapsed[i] + 1'b1;
            end
            default: begin
                // begin an armed run with every configured motor
                if (seq_mode == MODE_PENDING) begin
                    seq_count = 0;
                    for (i = 0; i < NMOT; i++) begin
                        if (mot_phase[i] == PH_CONF) begin
                            mot_elapsed[i] = '0;
                            mot_begin[i]   = TICK_W'(mot_dly[i]);
                            mot_end[i]     = TICK_W'(mot_dly[i]) + TICK_W'(mot_len[i]);
                            seq_count++;
                            mot_phase[i]   = PH_WAIT;
                        end
                    end
                    seq_drive = 1'b1;
                    seq_mode  = MODE_WORKING;
                end
                if (seq_mode == MODE_WORKING) begin
                    // start due motors, stop expired ones
                    for (i = 0; i < NMOT; i++) begin
                        if (mot_phase[i] == PH_WAIT) begin
                            if (mot_begin[i] <= mot_elapsed[i]) begin
                                mot_pwm[i]   = 1'b1;
                                mot_phase[i] = PH_RUN;
                            end
                        end else if (mot_phase[i] == PH_RUN) begin
                            if (mot_end[i] <= mot_elapsed[i]) begin
                                mot_pwm[i]     = 1'b0;
                                mot_phase[i]   = PH_DONE;
                                mot_duty_a[i]  = '0;
                                mot_duty_b[i]  = '0;
                                mot_begin[i]   = '0;
                                mot_end[i]     = '0;
                                mot_elapsed[i] = '0;
                            end
                        end
                    end
                    // retire finished motors, stop scanning once the run is empty
                    for (i = 0; i < NMOT; i++) begin
                        if (mot_phase[i] == PH_DONE) begin
                            if (seq_count > 0) seq_count--;
                            mot_phase[i] = PH_UNCONF;
                        end
                        if (seq_count == 0) begin
                            ending = 1'b1;
                            break;
                        end
                    end
                    if (ending) begin
                        seq_drive = 1'b0;
                        seq_mode  = MODE_READY;
                    end
                end
            end
        endcase
        r.mode  = seq_mode;
        r.drive = seq_drive;
        r.mask  = '0;
        for (i = 0; i < NMOT && i < MASK_W; i++)
            r.mask[i] = mot_pwm[i];
        r.status = hit ? mot_phase[m] : PH_UNCONF;
        r.duty_a = hit ? mot_duty_a[m] : '0;
        r.duty_b = hit ? mot_duty_b[m] : '0;
        r.active = CNT_OUT_W'(seq_count);
        return r;
    endfunction

    // one line per wrong field
    task automatic flag_mismatch(input string field, input int got, input int want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     reports_seen, field, got, want);
        mismatch_count++;
    endtask

    // send one input transaction after a random gap
    task automatic send_item(
        input logic [CMD_W-1:0] cmd,
        input logic [IDX_W-1:0] mi,
        input logic [WT_W-1:0]  wt,
        input logic [WT_W-1:0]  dl,
        input logic [DIR_W-1:0] dir,
        input logic [LVL_W-1:0] lvl
    );
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        due_reports.push_back(step_sequencer(cmd, mi, wt, dl, dir, lvl));
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_motor      <= mi;
        s_work_time  <= wt;
        s_delay_time <= dl;
        s_direction  <= dir;
        s_pwm_level  <= lvl;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // hold off the sender until every pending report has come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_reports.size() != 0);
    endtask

    // result side: compare with the oldest prediction, then draw a stall
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got_rep = '{m_module_state, m_driver_on, m_run_mask, m_motor_status,
                            m_duty_a, m_duty_b, m_active_count};
                if (due_reports.size() == 0) begin
                    flag_mismatch("unexpected result", 1, 0);
                end else begin
                    want_rep = due_reports.pop_front();
                    if (got_rep.mode !== want_rep.mode)
                        flag_mismatch("module_state", got_rep.mode, want_rep.mode);
                    if (got_rep.drive !== want_rep.drive)
                        flag_mismatch("driver_on", got_rep.drive, want_rep.drive);
                    if (got_rep.mask !== want_rep.mask)
                        flag_mismatch("run_mask", got_rep.mask, want_rep.mask);
                    if (got_rep.status !== want_rep.status)
                        flag_mismatch("motor_status", got_rep.status, want_rep.status);
                    if (got_rep.duty_a !== want_rep.duty_a)
                        flag_mismatch("duty_a", got_rep.duty_a, want_rep.duty_a);
                    if (got_rep.duty_b !== want_rep.duty_b)
                        flag_mismatch("duty_b", got_rep.duty_b, want_rep.duty_b);
                    if (got_rep.active !== want_rep.active)
                        flag_mismatch("active_count", got_rep.active, want_rep.active);
                end
                reports_seen++;
                ready_wait = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
                if (ready_wait != 0) m_ready <= 1'b0;
            end else if (!m_ready) begin
                if (ready_wait == 0) m_ready <= 1'b1;
                else ready_wait--;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // evaluates, ticks and starts on an empty sequencer change nothing
    task automatic test_idle_after_reset();
        send_item(CMD_EVAL, 3'd0, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_COUNT, 3'd4, 16'hFFFF, 16'hFFFF, DIR_HOLD, 8'd255);
        send_item(CMD_START, 3'd0, 16'h1234, 16'h0001, DIR_LEFT, 8'd7);
        send_item(CMD_START, 3'd7, 16'h0001, 16'h0000, DIR_RIGHT, 8'd9);
    endtask

    // field extremes, every direction, duty saturation and bad indexes
    task automatic test_configure_fields();
        send_item(CMD_CFG, 3'd0, 16'hFFFF, 16'hFFFF, DIR_HOLD, 8'd255);
        send_item(CMD_CFG, 3'd1, 16'h0000, 16'h0000, DIR_LEFT, 8'd0);
        send_item(CMD_CFG, 3'd2, 16'h0000, 16'h0000, DIR_RIGHT, 8'd100);
        send_item(CMD_CFG, 3'd3, 16'h0000, 16'h0000, DIR_STOP, 8'd170);
        send_item(CMD_CFG, 3'd4, 16'h0000, 16'hAAAA, DIR_LEFT, 8'd1);
        send_item(CMD_CFG, 3'd6, 16'h0001, 16'h0000, DIR_HOLD, 8'd50);
        send_item(CMD_CFG, 3'd7, 16'hFFFF, 16'hFFFF, DIR_HOLD, 8'd255);
        // shorten motor 0 again so the run can finish
        send_item(CMD_CFG, 3'd0, 16'h0001, 16'h0000, DIR_HOLD, 8'd101);
        send_item(CMD_CFG, 3'd5, 16'h0002, 16'h0001, DIR_RIGHT, 8'd85);
    endtask

    // start requests in every mode and the evaluate that begins the run
    task automatic test_start_and_begin();
        send_item(CMD_START, 3'd1, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_START, 3'd6, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_START, 3'd5, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_START, 3'd0, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_COUNT, 3'd5, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        // motor 0 has no delay and starts on the same evaluate
        send_item(CMD_EVAL, 3'd0, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_START, 3'd5, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_COUNT, 3'd0, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_EVAL, 3'd5, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
    endtask

    // sender waits for the result side to empty, then carries on
    task automatic test_drain_pause();
        wait_for_results();
        send_item(CMD_COUNT, 3'd2, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        wait_for_results();
    endtask

    // random runs: configure, start, then ticks and evaluates until the run ends
    task automatic test_random_runs();
        int               m;
        int               i;
        logic [WT_W-1:0]  wt;
        while (items_sent < RANDOM_ITEMS) begin
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 19;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
            if (seq_mode == MODE_READY) begin
                repeat ($urandom_range(1, 4))
                    send_item(CMD_CFG, $urandom_range(0, 7), $urandom_range(0, 2),
                              $urandom_range(0, 1), $urandom_range(0, 3),
                              $urandom_range(0, 255));
                // mostly name a configured motor
                m = $urandom_range(0, 7);
                if ($urandom_range(0, 3) != 0)
                    for (i = 0; i < NMOT; i++)
                        if (mot_phase[i] == PH_CONF) m = i;
                send_item(CMD_START, m, $urandom, $urandom, $urandom, $urandom);
                if ($urandom_range(0, 3) == 0)
                    send_item(CMD_START, $urandom_range(0, 7), $urandom, $urandom,
                              $urandom, $urandom);
                repeat ($urandom_range(0, 2))
                    send_item(CMD_COUNT, $urandom_range(0, 7), $urandom, $urandom,
                              $urandom, $urandom);
            end
            while (seq_mode != MODE_READY) begin
                repeat ($urandom_range(1, 40)) begin
                    m = $urandom_range(0, 7);
                    if ($urandom_range(0, 15) != 0) begin
                        send_item(CMD_COUNT, m, $urandom, $urandom, $urandom, $urandom);
                    end else begin
                        case ($urandom_range(0, 2))
                            0: send_item(CMD_START, m, $urandom, $urandom, $urandom, $urandom);
                            1: begin
                                // a motor in the run only gets a duty change
                                wt = $urandom_range(0, 2);
                                if (m < NMOT && (mot_phase[m] == PH_WAIT ||
                                                 mot_phase[m] == PH_RUN))
                                    wt = '0;
                                send_item(CMD_CFG, m, wt, $urandom_range(0, 1),
                                          $urandom_range(0, 3), $urandom_range(0, 255));
                            end
                            default: send_item(CMD_EVAL, m, $urandom, $urandom,
                                               $urandom, $urandom);
                        endcase
                    end
                end
                send_item(CMD_EVAL, $urandom_range(0, 7), $urandom, $urandom,
                          $urandom, $urandom);
            end
            if ($urandom_range(0, 4) == 0) wait_for_results();
        end
    endtask

    // reconfigure during a run: duty change in place, then a motor leaves the run
    task automatic test_reconfigure_in_run();
        gap_max   = 19;
        stall_max = 19;
        send_item(CMD_CFG, 3'd2, 16'h0001, 16'h0000, DIR_LEFT, 8'd40);
        send_item(CMD_CFG, 3'd3, 16'h0001, 16'h0000, DIR_RIGHT, 8'd60);
        send_item(CMD_START, 3'd2, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_EVAL, 3'd3, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        repeat (5) send_item(CMD_COUNT, 3'd2, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_CFG, 3'd2, 16'h0000, 16'h0000, DIR_HOLD, 8'd20);
        send_item(CMD_CFG, 3'd3, 16'h0003, 16'h0000, DIR_LEFT, 8'd50);
        repeat (110) send_item(CMD_COUNT, 3'd3, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_EVAL, 3'd2, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_START, 3'd3, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
        send_item(CMD_EVAL, 3'd3, 16'h0000, 16'h0000, DIR_STOP, 8'd0);
    endtask

    initial begin
        // model reset state
        for (int i = 0; i < NMOT; i++) begin
            mot_phase[i]   = PH_UNCONF;
            mot_len[i]     = '0;
            mot_dly[i]     = '0;
            mot_elapsed[i] = '0;
            mot_begin[i]   = '0;
            mot_end[i]     = '0;
            mot_dir[i]     = DIR_STOP;
            mot_duty_a[i]  = '0;
            mot_duty_b[i]  = '0;
            mot_pwm[i]     = 1'b0;
        end
        seq_mode  = MODE_READY;
        seq_count = 0;
        seq_drive = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_after_reset();
        test_configure_fields();
        test_start_and_begin();
        test_drain_pause();
        test_random_runs();
        test_reconfigure_in_run();

        // let the last results come back
        s_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
